// File: design/dcf_pkg.sv
// Shared constants and codes for the delimited command framer.
package dcf_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned TICKS_W         = 16;
    localparam int unsigned INDEX_W         = 4;
    localparam int unsigned FRAME_BYTES_DEF = 12;
    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd2000;

    // input kinds
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_GAP  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_ACK      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_NONE  = 8'hFF;

endpackage

// File: design/delimited_command_framer.sv
// Framer for '#'...';' delimited commands: stores the frame in a small memory,
// replays it on the closing byte with ACK status, and reports OVERFLOW, TIMEOUT
// or ERROR as single results. An input word is taken only while the output register
// is free. A closing ';' starts a burst of n results (n = frame length, 2..FRAME_BYTES);
// each result is read from the single registered memory read port (S_RD) and then
// handed out (S_SEND), and no input word is taken until the burst has been handed out.
// Received byte 0xFF behaves as a gap. No clearing pass follows reset.
module delimited_command_framer #(
    parameter int unsigned FRAME_BYTES = dcf_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: timeout_ticks
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] frame_byte, [11:8] byte_index, [15:12] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import dcf_pkg::*;

    localparam int unsigned AW = $clog2(FRAME_BYTES);
    localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
    localparam logic [CW-1:0] FULL = CW'(FRAME_BYTES);
    localparam logic [CW-1:0] ONE  = CW'(1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_OPEN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_RD    = 5'b01000,
        S_SEND  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_k, n_k;
    logic [CW-1:0]       r_n, n_n;
    logic [TICKS_W-1:0]  r_elapsed, n_elapsed;
    logic [TICKS_W-1:0]  r_timeout;

    logic                r_m_valid, n_m_valid;
    logic [1:0]          r_m_status, n_m_status;
    logic [BYTE_W-1:0]   r_m_byte, n_m_byte;
    logic [INDEX_W-1:0]  r_m_index, n_m_index;
    logic                r_m_last, n_m_last;

    logic                w_we, w_re;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [BYTE_W-1:0]   w_wdata, w_rdata;

    logic                w_accept, w_out_free;
    logic                w_gap, w_data, w_tick;
    logic [BYTE_W-1:0]   w_b;
    logic [TICKS_W-1:0]  w_elapsed_inc;
    logic [CW+INDEX_W-1:0] w_k_ext;
    logic                w_k_last;

    assign o_cfg_ready = 1'b1;

    assign w_out_free = !r_m_valid || m_tready;
    assign s_tready   = ((r_state == S_IDLE) || (r_state == S_OPEN) ||
                         (r_state == S_DRAIN)) && w_out_free;
    assign w_accept   = s_tvalid && s_tready;

    assign w_b    = s_tdata;
    assign w_data = (s_tuser == CMD_BYTE) && (w_b != CH_NONE);
    assign w_gap  = (s_tuser == CMD_GAP) || ((s_tuser == CMD_BYTE) && (w_b == CH_NONE));
    assign w_tick = (s_tuser == CMD_TICK);

    assign w_elapsed_inc = r_elapsed + TICKS_W'(1);
    assign w_k_ext       = {{INDEX_W{1'b0}}, r_k};
    assign w_k_last      = ((r_k + ONE) == r_n);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_k        = r_k;
        n_n        = r_n;
        n_elapsed  = r_elapsed;
        n_m_valid  = r_m_valid && !m_tready;
        n_m_status = r_m_status;
        n_m_byte   = r_m_byte;
        n_m_index  = r_m_index;
        n_m_last   = r_m_last;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = w_b;
        w_re       = 1'b0;
        w_raddr    = r_k[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept && w_data) begin
                    if (w_b == CH_OPEN) begin
                        w_we      = 1'b1;
                        w_waddr   = '0;
                        n_fill    = ONE;
                        n_elapsed = '0;
                        n_state   = S_OPEN;
                    end else begin
                        n_m_valid  = 1'b1;
                        n_m_status = ST_ERROR;
                        n_m_byte   = '0;
                        n_m_index  = '0;
                        n_m_last   = 1'b1;
                        n_fill     = '0;
                        n_state    = S_DRAIN;
                    end
                end
            end
            S_OPEN: begin
                if (w_accept && w_data) begin
                    if (r_fill >= FULL) begin
                        n_m_valid  = 1'b1;
                        n_m_status = ST_OVERFLOW;
                        n_m_byte   = '0;
                        n_m_index  = '0;
                        n_m_last   = 1'b1;
                        n_fill     = '0;
                        n_state    = S_DRAIN;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_fill[AW-1:0];
                        if (w_b == CH_CLOSE) begin
                            // replay slots 0..fill, closing byte included
                            n_n     = r_fill + ONE;
                            n_k     = '0;
                            n_fill  = '0;
                            n_state = S_RD;
                        end else begin
                            n_fill = r_fill + ONE;
                        end
                    end
                end else if (w_accept && w_tick) begin
                    n_elapsed = w_elapsed_inc;
                    if (w_elapsed_inc >= r_timeout) begin
                        n_m_valid  = 1'b1;
                        n_m_status = ST_TIMEOUT;
                        n_m_byte   = '0;
                        n_m_index  = '0;
                        n_m_last   = 1'b1;
                        n_fill     = '0;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_DRAIN: begin
                if (w_accept && w_gap) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                w_re    = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                // hold read data until the output register frees up
                if (w_out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_status = ST_ACK;
                    n_m_byte   = w_rdata;
                    n_m_index  = w_k_ext[INDEX_W-1:0];
                    n_m_last   = w_k_last;
                    n_k        = r_k + ONE;
                    n_state    = w_k_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_k       <= '0;
            r_n       <= '0;
            r_elapsed <= '0;
            r_timeout <= TIMEOUT_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_k       <= n_k;
            r_n       <= n_n;
            r_elapsed <= n_elapsed;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_status <= n_m_status;
        r_m_byte   <= n_m_byte;
        r_m_index  <= n_m_index;
        r_m_last   <= n_m_last;
    end

    dcf_store #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(16 - BYTE_W - INDEX_W){1'b0}}, r_m_index, r_m_byte};
    assign m_tuser  = r_m_status;
    assign m_tlast  = r_m_last;

    // an open frame always holds '#' and never more than the store
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OPEN) |-> (r_fill >= ONE) && (r_fill <= FULL))
        else $error("fill position out of range while frame open");

    // burst index stays below the burst length
    a_burst_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_SEND)) |-> (r_k < r_n))
        else $error("burst index past frame length");

    // non-ack results are single words with zero payload
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_status != ST_ACK)) |-> (r_m_last && (r_m_byte == '0) &&
                                                  (r_m_index == '0)))
        else $error("status result carries payload or lacks last");

    // the final burst word returns the framer to idle
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEND) && w_out_free && w_k_last) |=> (r_state == S_IDLE))
        else $error("framer not idle after final burst word");

    // no input word is taken during a burst
    a_burst_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_SEND)) |-> !w_accept)
        else $error("input accepted during burst");

endmodule

// File: design/dcf_store.sv
// Frame byte memory: one write port, one registered read port.
module dcf_store #(
    parameter int unsigned DEPTH = dcf_pkg::FRAME_BYTES_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [dcf_pkg::BYTE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [dcf_pkg::BYTE_W-1:0] o_rdata
);
    import dcf_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
